/* hw/rtl/lthr_pkg.sv */
// ---------------------------------------------------------------------------
// Light threshold receiver package
// Shared widths, reset values, register indexes and types.
// ---------------------------------------------------------------------------
package lthr_pkg;

  localparam int unsigned SampleW   = 10;
  localparam int unsigned SDataW    = 16;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned DataBits  = 8;
  localparam int unsigned ThreshW   = 10;
  localparam int unsigned PeriodW   = 16;
  localparam int unsigned CountW    = 17;
  localparam int unsigned BitsW     = 4;
  localparam int unsigned BitIdxW   = $clog2(ByteW);
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [ThreshW-1:0] ThreshReset = ThreshW'(800);
  localparam logic [PeriodW-1:0] PeriodReset = PeriodW'(50);

  localparam logic [CfgIdxW-1:0] CfgThreshold = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgPeriod    = CfgIdxW'(1);

  typedef enum logic [1:0] {
    PhaseIdle,
    PhaseData,
    PhaseStop
  } phase_e;

  typedef struct packed {
    logic [ThreshW-1:0] threshold;
    logic [PeriodW-1:0] period;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic level;
  } lvl_t;

endpackage

/* hw/rtl/lthr_cfg_regs.sv */
// ---------------------------------------------------------------------------
// Configuration registers
// Holds the light threshold and the bit period, written by index.
// ---------------------------------------------------------------------------
module lthr_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lthr_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [lthr_pkg::CfgDataW-1:0]  cfg_data_i,
  output lthr_pkg::cfg_t                 cfg_o
);
  import lthr_pkg::*;

  logic [ThreshW-1:0] thresh_q, thresh_d;
  logic [PeriodW-1:0] period_q, period_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    thresh_d = thresh_q;
    period_d = period_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgThreshold: thresh_d = cfg_data_i[ThreshW-1:0];
        CfgPeriod:    period_d = cfg_data_i[PeriodW-1:0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= ThreshReset;
      period_q <= PeriodReset;
    end else begin
      thresh_q <= thresh_d;
      period_q <= period_d;
    end
  end

  assign cfg_o.threshold = thresh_q;
  assign cfg_o.period    = period_q;

endmodule

/* hw/rtl/lthr_slicer.sv */
// ---------------------------------------------------------------------------
// Level slicer
// Compares each sample with the threshold and registers the light level.
// ---------------------------------------------------------------------------
module lthr_slicer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [lthr_pkg::SDataW-1:0]   s_axis_tdata,
  input  logic [lthr_pkg::ThreshW-1:0]  threshold_i,
  input  logic                          advance_i,
  output lthr_pkg::lvl_t                lvl_o
);
  import lthr_pkg::*;

  logic             valid_q, valid_d;
  logic             level_q, level_d;
  logic [SampleW-1:0] sample;

  assign sample        = s_axis_tdata[SampleW-1:0];
  assign s_axis_tready = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    level_d = level_q;
    if (advance_i) begin
      valid_d = 1'b0;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      valid_d = 1'b1;
      level_d = sample > threshold_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    level_q <= level_d;
  end

  assign lvl_o.valid = valid_q;
  assign lvl_o.level = level_q;

endmodule

/* hw/rtl/lthr_rx_core.sv */
// ---------------------------------------------------------------------------
// Receiver core
// Start-bit detection, bit timing, data shift and result register.
// ---------------------------------------------------------------------------
module lthr_rx_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [lthr_pkg::PeriodW-1:0]  period_i,
  input  lthr_pkg::lvl_t                lvl_i,
  output logic                          advance_o,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [lthr_pkg::ByteW-1:0]    m_axis_tdata
);
  import lthr_pkg::*;

  phase_e             phase_q, phase_d;
  logic               prev_q, prev_d;
  logic [CountW-1:0]  cnt_q, cnt_d;
  logic [BitsW-1:0]   bits_q, bits_d;
  logic [ByteW-1:0]   shift_q, shift_d;
  logic               ovalid_q, ovalid_d;
  logic [ByteW-1:0]   obyte_q, obyte_d;

  logic [PeriodW-1:0] eff_p;
  logic [CountW-1:0]  first_wait;
  logic [CountW-1:0]  cnt_dec;
  logic [BitsW-1:0]   bits_inc;
  logic               out_free;
  logic               due;
  logic               stop_due;
  logic               emit;

  assign out_free   = !ovalid_q || m_axis_tready;
  assign eff_p      = (period_i == '0) ? PeriodW'(1) : period_i;
  assign first_wait = {1'b0, eff_p} + {2'b00, eff_p[PeriodW-1:1]};
  assign cnt_dec    = (cnt_q != '0) ? cnt_q - CountW'(1) : cnt_q;
  assign due        = (cnt_dec == '0);
  assign bits_inc   = bits_q + BitsW'(1);
  assign stop_due   = (phase_q != PhaseIdle) && (phase_q != PhaseData) && due;
  assign advance_o  = lvl_i.valid && (out_free || !stop_due);

  always_comb begin
    emit = 1'b0;
    case (phase_q)
      PhaseIdle: emit = 1'b0;
      PhaseData: emit = 1'b0;
      default:   emit = advance_o && due;
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    prev_d  = prev_q;
    cnt_d   = cnt_q;
    bits_d  = bits_q;
    shift_d = shift_q;
    if (advance_o) begin
      case (phase_q)
        PhaseIdle: begin
          if (prev_q && !lvl_i.level) begin
            cnt_d   = first_wait;
            bits_d  = '0;
            shift_d = '0;
            phase_d = PhaseData;
          end
          prev_d = lvl_i.level;
        end
        PhaseData: begin
          cnt_d = cnt_dec;
          if (due) begin
            if (bits_q < BitsW'(ByteW) && lvl_i.level) begin
              shift_d[bits_q[BitIdxW-1:0]] = 1'b1;
            end
            bits_d = bits_inc;
            cnt_d  = {1'b0, eff_p};
            if (bits_inc >= BitsW'(DataBits)) begin
              phase_d = PhaseStop;
            end
          end
        end
        default: begin
          cnt_d = cnt_dec;
          if (due) begin
            phase_d = PhaseIdle;
            prev_d  = 1'b0;
            cnt_d   = '0;
            bits_d  = '0;
          end
        end
      endcase
    end
  end

  always_comb begin
    ovalid_d = ovalid_q;
    obyte_d  = obyte_q;
    if (m_axis_tready) begin
      ovalid_d = 1'b0;
    end
    if (emit) begin
      ovalid_d = 1'b1;
      obyte_d  = shift_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhaseIdle;
      prev_q   <= 1'b0;
      cnt_q    <= '0;
      bits_q   <= '0;
      shift_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      prev_q   <= prev_d;
      cnt_q    <= cnt_d;
      bits_q   <= bits_d;
      shift_q  <= shift_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    obyte_q <= obyte_d;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = obyte_q;

endmodule

/* hw/rtl/light_threshold_uart_receiver.sv */
// ---------------------------------------------------------------------------
// Light threshold UART receiver
// Recovers 8N1 characters from a stream of light-sensor samples.
// ---------------------------------------------------------------------------
// One sample word is taken per tick, every cycle, and stands for one bit-timing
// tick. A sample above the threshold register is light on. A fall from light to
// dark while idle starts a frame; bit 0 is sampled 1.5 bit periods later, the
// rest one period apart, LSB first, and the byte leaves one period after bit 7.
// The word that completes a frame passes through the slicer register and then
// the result register before the byte is offered. A stalled result holds back
// the sample side only when the next frame completes before the waiting byte
// has left; otherwise a word is taken in every cycle. Write configuration only
// while no frame is in progress.
module light_threshold_uart_receiver (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [lthr_pkg::SDataW-1:0]   s_axis_tdata,   // [9:0] light_sample
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [lthr_pkg::ByteW-1:0]    m_axis_tdata,   // [7:0] received_byte
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lthr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [lthr_pkg::CfgDataW-1:0] cfg_data_i
);
  import lthr_pkg::*;

  cfg_t cfg;
  lvl_t lvl;
  logic advance;

  lthr_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  lthr_slicer u_slicer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .threshold_i   (cfg.threshold),
    .advance_i     (advance),
    .lvl_o         (lvl)
  );

  lthr_rx_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .period_i      (cfg.period),
    .lvl_i         (lvl),
    .advance_o     (advance),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

/* hw/rtl/lthr_checker.sv */
// ---------------------------------------------------------------------------
// Receiver port checker
// Port-level properties of the receiver, bound to the top level.
// ---------------------------------------------------------------------------
module lthr_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [lthr_pkg::ByteW-1:0]    m_axis_tdata,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result word right after reset");

  a_frame_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid)
    else $error("two result words in back-to-back cycles");

  a_in_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid && s_axis_tvalid |-> s_axis_tready)
    else $error("sample word refused with an empty result register");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write refused");

endmodule

bind light_threshold_uart_receiver lthr_checker u_lthr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .cfg_valid_i   (cfg_valid_i),
  .cfg_ready_o   (cfg_ready_o)
);

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Light threshold UART receiver testbench
// Drives sample words with random gaps and result stalls, and checks every
// received byte against a cycle-free decoder of the light link. A directed
// table comes first: threshold boundaries, masked sample bits, the shortest
// periods and unused register indexes. Random frames follow over many
// register settings.
// ---------------------------------------------------------------------------
module tb_top;

  import lthr_pkg::*;

  localparam int unsigned SampleMax  = (1 << SampleW) - 1;
  localparam int unsigned PipeDrain  = 8;
  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned PlanLen    = 27;
  localparam int unsigned WordTarget = 800;

  localparam logic [CfgIdxW-1:0] CfgSpare2 = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CfgSpare3 = CfgIdxW'(3);

  typedef enum logic {RowTick, RowReg} row_kind_e;

  typedef struct packed {
    row_kind_e           kind;
    logic [CfgIdxW-1:0]  idx;
    logic [SDataW-1:0]   val;
    logic                typed;
    logic [ByteW-1:0]    chr;
  } row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [SDataW-1:0]   s_axis_tdata;   // [9:0] light_sample
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [ByteW-1:0]    m_axis_tdata;   // [7:0] received_byte
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  light_threshold_uart_receiver u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // decoder state
  logic [ThreshW-1:0] lt_thresh;
  logic [PeriodW-1:0] lt_period;
  phase_e             lt_phase;
  logic               lt_prev;
  logic [CountW-1:0]  lt_count;
  logic [BitsW-1:0]   lt_bits;
  logic [ByteW-1:0]   lt_shift;

  logic [ByteW-1:0] due_bytes[$];
  int unsigned      words_sent;
  int unsigned      errs;
  int unsigned      quiet_cycles;
  int unsigned      gap_max;
  int unsigned      stall_max;

  row_t plan [0:PlanLen-1] = '{
    '{RowReg,  CfgPeriod,    16'h0000, 1'b0, 8'h00},
    '{RowTick, '0,           16'h03FF, 1'b0, 8'h00},
    '{RowTick, '0,           16'h0000, 1'b0, 8'h00},
    '{RowTick, '0,           16'h0321, 1'b0, 8'h00},
    '{RowTick, '0,           16'h0320, 1'b0, 8'h00},
    '{RowTick, '0,           16'h03FF, 1'b0, 8'h00},
    '{RowTick, '0,           16'h0000, 1'b0, 8'h00},
    '{RowTick, '0,           16'hFC00, 1'b0, 8'h00},
    '{RowTick, '0,           16'h0321, 1'b0, 8'h00},
    '{RowTick, '0,           16'hFFFF, 1'b0, 8'h00},
    '{RowTick, '0,           16'h0000, 1'b0, 8'h00},
    '{RowTick, '0,           16'h03FF, 1'b1, 8'h65},
    '{RowReg,  CfgThreshold, 16'hFC00, 1'b0, 8'h00},
    '{RowReg,  CfgSpare2,    16'hFFFF, 1'b0, 8'h00},
    '{RowReg,  CfgSpare3,    16'hFFFF, 1'b0, 8'h00},
    '{RowReg,  CfgPeriod,    16'h0001, 1'b0, 8'h00},
    '{RowTick, '0,           16'h0001, 1'b0, 8'h00},
    '{RowTick, '0,           16'h0000, 1'b0, 8'h00},
    '{RowTick, '0,           16'h0001, 1'b0, 8'h00},
    '{RowTick, '0,           16'h0000, 1'b0, 8'h00},
    '{RowTick, '0,           16'h0002, 1'b0, 8'h00},
    '{RowTick, '0,           16'h0000, 1'b0, 8'h00},
    '{RowTick, '0,           16'h0200, 1'b0, 8'h00},
    '{RowTick, '0,           16'h0000, 1'b0, 8'h00},
    '{RowTick, '0,           16'h03FF, 1'b0, 8'h00},
    '{RowTick, '0,           16'h0000, 1'b0, 8'h00},
    '{RowTick, '0,           16'h0000, 1'b1, 8'h55}
  };

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  task automatic decode_tick(input logic [SDataW-1:0] word, output bit got,
                             output logic [ByteW-1:0] chr);
    logic        lvl;
    int unsigned pe;
    lvl = word[SampleW-1:0] > lt_thresh;
    pe  = (lt_period == '0) ? 1 : int'(lt_period);
    got = 1'b0;
    chr = '0;
    if (lt_phase == PhaseIdle) begin
      if (lt_prev && !lvl) begin
        lt_count = CountW'((3 * pe) / 2);
        lt_bits  = '0;
        lt_shift = '0;
        lt_phase = PhaseData;
      end
      lt_prev = lvl;
    end else begin
      if (lt_count != '0) lt_count = lt_count - 1'b1;
      if (lt_count == '0) begin
        if (lt_phase == PhaseData) begin
          if (lt_bits < ByteW && lvl) lt_shift[lt_bits[BitIdxW-1:0]] = 1'b1;
          lt_bits  = lt_bits + 1'b1;
          lt_count = CountW'(pe);
          if (lt_bits >= DataBits) lt_phase = PhaseStop;
        end else begin
          got      = 1'b1;
          chr      = lt_shift;
          lt_phase = PhaseIdle;
          lt_prev  = 1'b0;
          lt_count = '0;
          lt_bits  = '0;
        end
      end
    end
  endtask

  function automatic logic [SDataW-1:0] level_word(input bit lvl);
    logic [SampleW-1:0] smp;
    if (lvl && lt_thresh != SampleW'(SampleMax)) begin
      smp = SampleW'($urandom_range(32'(lt_thresh) + 1, SampleMax));
    end else if (lvl) begin
      smp = SampleW'($urandom_range(0, SampleMax));
    end else begin
      smp = SampleW'($urandom_range(0, 32'(lt_thresh)));
    end
    return SDataW'(smp);
  endfunction

  function automatic logic [SDataW-1:0] noise_word();
    logic [SDataW-SampleW-1:0] upper;
    upper = ($urandom_range(0, 15) == 0) ? (SDataW-SampleW)'($urandom) : '0;
    return {upper, SampleW'($urandom)};
  endfunction

  task automatic send_word(input logic [SDataW-1:0] word, input bit typed,
                           input logic [ByteW-1:0] typed_chr);
    int unsigned      gap;
    bit               got;
    logic [ByteW-1:0] chr;
    gap = $urandom_range(0, gap_max);
    repeat (gap) @(negedge clk_i) s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    do @(posedge clk_i); while (!s_axis_tready);
    decode_tick(word, got, chr);
    if (typed) due_bytes.push_back(typed_chr);
    else if (got) due_bytes.push_back(chr);
    words_sent++;
  endtask

  task automatic send_frame(input int unsigned per, input bit broken);
    int unsigned      pe;
    int unsigned      slot;
    logic [ByteW-1:0] chr;
    bit               lvl;
    pe  = (per == 0) ? 1 : per;
    chr = ByteW'($urandom);
    repeat ($urandom_range(1, 3)) send_word(level_word(1'b1), 1'b0, '0);
    for (int s = 0; s < 10; s++) begin
      lvl  = (s == 0) ? 1'b0 : (s == 9) ? 1'b1 : chr[s-1];
      slot = pe;
      if (pe >= 3 && pe <= 16 && $urandom_range(0, 3) == 0) slot = pe + $urandom_range(0, 2) - 1;
      if (s == 9) slot = pe + ((pe <= 16) ? $urandom_range(0, pe) : 0);
      repeat (slot) send_word(broken ? noise_word() : level_word(lvl), 1'b0, '0);
    end
  endtask

  // finish any frame, drop valid and let the pipeline empty
  task automatic settle();
    while (lt_phase != PhaseIdle) send_word('0, 1'b0, '0);
    @(negedge clk_i) s_axis_tvalid <= 1'b0;
    while (due_bytes.size() != 0) @(posedge clk_i);
    repeat (PipeDrain) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgThreshold: lt_thresh = val[ThreshW-1:0];
      CfgPeriod:    lt_period = val[PeriodW-1:0];
      default: ;
    endcase
    @(negedge clk_i) cfg_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin : rx_check
    logic [ByteW-1:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (due_bytes.size() == 0) begin
        $error("received_byte: expected none, actual %h", m_axis_tdata);
        errs++;
      end else begin
        want = due_bytes.pop_front();
        if (m_axis_tdata !== want) begin
          $error("received_byte: expected %h, actual %h", want, m_axis_tdata);
          errs++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("light_threshold_uart_receiver verification failed");
        $finish;
      end
    end
  end

  initial begin : sink_ctl
    int unsigned stall;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = $urandom_range(0, stall_max);
      if (stall != 0) begin
        @(negedge clk_i) m_axis_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
        @(negedge clk_i) m_axis_tready <= 1'b1;
      end else if (!m_axis_tready) begin
        @(negedge clk_i) m_axis_tready <= 1'b1;
      end
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  initial begin : stim
    int unsigned        phase_no;
    int unsigned        phase_start;
    int unsigned        budget;
    int unsigned        per;
    int unsigned        pick;
    logic [ThreshW-1:0] thr;

    rst_ni          = 1'b0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = CfgThreshold;
    cfg_data_i      = '0;
    lt_thresh       = ThreshReset;
    lt_period       = PeriodReset;
    lt_phase        = PhaseIdle;
    lt_prev         = 1'b0;
    lt_count        = '0;
    lt_bits         = '0;
    lt_shift        = '0;
    words_sent      = 0;
    errs            = 0;
    quiet_cycles    = 0;
    gap_max         = 5;
    stall_max       = 5;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    for (int r = 0; r < PlanLen; r++) begin
      if (plan[r].kind == RowReg) begin
        settle();
        write_reg(plan[r].idx, plan[r].val);
      end else begin
        send_word(plan[r].val, plan[r].typed, plan[r].chr);
      end
    end

    phase_no = 0;
    while (words_sent < WordTarget) begin
      settle();
      case (phase_no % 6)
        1:       thr = ThreshW'(SampleMax);
        4:       thr = '0;
        default: thr = ThreshW'($urandom_range(1, SampleMax - 1));
      endcase
      case (phase_no % 7)
        3:       per = 0;
        5:       per = 1;
        6:       per = $urandom_range(8, 12);
        default: per = $urandom_range(2, 6);
      endcase
      write_reg(CfgThreshold, {(CfgDataW-ThreshW)'($urandom), thr});
      write_reg(CfgPeriod, CfgDataW'(per));
      gap_max     = (phase_no % 3 == 2) ? 0 : 5;
      stall_max   = (phase_no % 4 == 3) ? 0 : 5;
      budget      = (thr == ThreshW'(SampleMax)) ? 40 : 120;
      phase_start = words_sent;
      while (words_sent - phase_start < budget) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          repeat ($urandom_range(1, 8)) send_word(noise_word(), 1'b0, '0);
        end else begin
          send_frame(per, pick == 1);
        end
      end
      phase_no++;
    end

    settle();
    if (errs == 0) begin
      $display("light_threshold_uart_receiver verification clean");
    end else begin
      $display("light_threshold_uart_receiver verification failed");
    end
    $finish;
  end

endmodule
